// ----- sv/swm_pkg.sv -----
// Shared types and constants for the star wildcard matcher.
// Holds the opcode codes, the decoded command word and the pattern defaults.
// No dependencies.
package swm_pkg;

    localparam int PATTERN_CAPACITY_DEF = 32;
    localparam logic [7:0] STAR_BYTE = 8'h2A;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_TEXT   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        CMD_CLEAR  = 4'b0001,
        CMD_APPEND = 4'b0010,
        CMD_BEGIN  = 4'b0100,
        CMD_TEXT   = 4'b1000
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data_byte;
    } cmd_t;

endpackage

// ----- sv/swm_front.sv -----
// Input stage of the star wildcard matcher: accepts words and decodes the opcode.
// Depends on swm_pkg for the opcode and command types.
module swm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [1:0]    s_axis_tuser,   // [1:0] opcode
    input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output swm_pkg::cmd_t cmd
);
    import swm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cmd_t      cmd_reg;
    cmd_kind_t kind_dec;

    assign s_axis_tready = !valid_reg || cmd_ready;
    assign cmd_valid     = valid_reg;
    assign cmd           = cmd_reg;

    always_comb
    begin
        unique case (opcode_t'(s_axis_tuser))
            OP_CLEAR:  kind_dec = CMD_CLEAR;
            OP_APPEND: kind_dec = CMD_APPEND;
            OP_BEGIN:  kind_dec = CMD_BEGIN;
            OP_TEXT:   kind_dec = CMD_TEXT;
            default:   kind_dec = CMD_TEXT;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg.kind      <= kind_dec;
            cmd_reg.data_byte <= s_axis_tdata;
        end
    end

endmodule

// ----- sv/swm_queue.sv -----
// Two-entry command queue between the decode stage and the match engine.
// Depends on swm_pkg for the command type.
module swm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  swm_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output swm_pkg::cmd_t out_cmd
);
    import swm_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'(QUEUE_DEPTH);
    assign out_valid = count_reg != 2'd0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- sv/swm_back.sv -----
// Match engine: pattern store, live-position vector and the result register.
// Depends on swm_pkg for the command type and the star byte.
module swm_back #(
    parameter int PATTERN_CAPACITY = swm_pkg::PATTERN_CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  swm_pkg::cmd_t cmd,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
    import swm_pkg::*;

    localparam int LEN_W  = $clog2(PATTERN_CAPACITY + 1);
    localparam int LIVE_W = PATTERN_CAPACITY + 1;

    logic [7:0]        store_reg [PATTERN_CAPACITY];
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [LIVE_W-1:0] live_reg;
    logic [LIVE_W-1:0] live_next;
    logic [LIVE_W-1:0] init_reg;
    logic [LIVE_W-1:0] init_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_matched_reg;
    logic              out_ovf_reg;
    logic              matched_next;

    logic [LIVE_W-1:0] star_m;
    logic [LIVE_W-1:0] eq_m;
    logic [LIVE_W-1:0] step;
    logic [LIVE_W-1:0] gen;
    logic [LIVE_W-1:0] sum;
    logic [LIVE_W-1:0] carry;
    logic [LIVE_W-1:0] adv;
    logic [LIVE_W-1:0] init_app;
    logic              full;
    logic              take;
    logic              is_star;

    assign cmd_ready     = !out_valid_reg || m_axis_tready;
    assign take          = cmd_valid && cmd_ready;
    assign full          = len_reg == LEN_W'(PATTERN_CAPACITY);
    assign is_star       = cmd.data_byte == STAR_BYTE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_ovf_reg, out_matched_reg};

    always_comb
    begin
        star_m = '0;
        eq_m   = '0;
        for (int i = 0; i < PATTERN_CAPACITY; i++)
        begin
            if (LEN_W'(i) < len_reg)
            begin
                star_m[i] = store_reg[i] == STAR_BYTE;
                eq_m[i]   = store_reg[i] == cmd.data_byte;
            end
        end
    end

    // A star keeps its position live; a star or an equal byte moves it on by one.
    // The star closure is a carry chain: stars propagate, live stars generate.
    assign step  = (live_reg & star_m) | ((live_reg & (star_m | eq_m)) << 1);
    assign gen   = step & star_m;
    assign sum   = star_m + gen;
    assign carry = sum ^ star_m ^ gen;
    assign adv   = step | carry;

    // The empty-text set grows only while the pattern holds nothing but stars.
    always_comb
    begin
        init_app[0] = init_reg[0];
        for (int j = 1; j < LIVE_W; j++)
        begin
            init_app[j] = init_reg[j]
                || (init_reg[j-1] && len_reg == LEN_W'(j - 1) && is_star);
        end
    end

    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        live_next      = live_reg;
        init_next      = init_reg;
        matched_next   = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (take)
        begin
            out_valid_next = 1'b1;
            unique case (cmd.kind)
                CMD_CLEAR:
                begin
                    len_next  = '0;
                    ovf_next  = 1'b0;
                    live_next = LIVE_W'(1);
                    init_next = LIVE_W'(1);
                end
                CMD_APPEND:
                begin
                    if (!full)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    init_next = init_app;
                    live_next = init_app;
                end
                CMD_BEGIN:
                begin
                    live_next    = init_reg;
                    matched_next = init_reg[len_reg];
                end
                CMD_TEXT:
                begin
                    live_next    = adv;
                    matched_next = adv[len_reg];
                end
                default:
                begin
                    matched_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            live_reg      <= LIVE_W'(1);
            init_reg      <= LIVE_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            live_reg      <= live_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_matched_reg <= matched_next;
            out_ovf_reg     <= ovf_next;
        end
        for (int i = 0; i < PATTERN_CAPACITY; i++)
        begin
            if (take && cmd.kind == CMD_APPEND && len_reg == LEN_W'(i))
            begin
                store_reg[i] <= cmd.data_byte;
            end
        end
    end

endmodule

// ----- sv/star_wildcard_matcher.sv -----
// Top level of the star wildcard matcher: decode stage, command queue, match engine.
// Depends on swm_pkg, swm_front, swm_queue and swm_back.
//
//   Channel   Dir   Bits used                          Meaning
//   s_axis    in    tuser[1:0] opcode, tdata[7:0] byte  pattern or text operation
//   m_axis    out   tdata[0] matched, tdata[1] ovf      one result word per input word
//
// One word is accepted per cycle while s_axis_tready is high; the result passes through
// the decode register, a queue entry and the result register. The rate is set by the
// combinational update of the live position vector, a PATTERN_CAPACITY+1 bit carry add.
// Reset empties the pattern, clears the overflow flag and leaves position zero live.
// A stalled output fills the two-entry queue, after which s_axis_tready drops.
module star_wildcard_matcher #(
    parameter int PATTERN_CAPACITY = swm_pkg::PATTERN_CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [1:0] s_axis_tuser,   // [1:0] opcode
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
    import swm_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_ready;
    cmd_t queue_cmd;

    swm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .cmd_valid     (front_valid),
        .cmd_ready     (front_ready),
        .cmd           (front_cmd)
    );

    swm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    swm_back #(
        .PATTERN_CAPACITY (PATTERN_CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (queue_valid),
        .cmd_ready     (queue_ready),
        .cmd           (queue_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- sv/swm_checker.sv -----
// Port-level checks for the star wildcard matcher, bound to the top level.
// Depends only on the ports of star_wildcard_matcher.
module swm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0)
        else $error("padding bits of result word not zero");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready && $past(m_axis_tready) && $past(m_axis_tready, 2) |-> s_axis_tready)
        else $error("input stalled although the output drains");

endmodule

bind star_wildcard_matcher swm_checker u_swm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for star_wildcard_matcher, an anchored glob matcher where only '*' is special.
// It runs directed words, then random pattern and text sequences, and checks each result word against a
// live-position model, or the table's bits for typed rows. Depends on swm_pkg and the matcher RTL.
module testbench;

    import swm_pkg::*;

    localparam int PAT_CAP = PATTERN_CAPACITY_DEF;
    localparam int RANDOM_WORDS = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIRECTED_ROWS = 29;
    localparam logic [PAT_CAP:0] LIVE_ONE = {{PAT_CAP{1'b0}}, 1'b1};

    typedef struct packed {
        opcode_t    op;
        logic [7:0] data;
        logic [7:0] reps;
        logic       typed;
        logic       want_matched;
        logic       want_overflow;
    } stim_row_t;

    typedef struct {
        logic matched;
        logic overflow;
    } match_result_t;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{OP_BEGIN,  8'h00, 8'd1,  1'b1, 1'b1, 1'b0},
        '{OP_TEXT,   8'h00, 8'd1,  1'b1, 1'b0, 1'b0},
        '{OP_TEXT,   8'hFF, 8'd1,  1'b1, 1'b0, 1'b0},
        '{OP_BEGIN,  8'hFF, 8'd1,  1'b1, 1'b1, 1'b0},
        '{OP_APPEND, STAR_BYTE, 8'd1, 1'b1, 1'b0, 1'b0},
        '{OP_BEGIN,  8'h00, 8'd1,  1'b1, 1'b1, 1'b0},
        '{OP_TEXT,   8'hFF, 8'd1,  1'b1, 1'b1, 1'b0},
        '{OP_TEXT,   8'h00, 8'd1,  1'b1, 1'b1, 1'b0},
        '{OP_CLEAR,  8'h55, 8'd1,  1'b1, 1'b0, 1'b0},
        '{OP_APPEND, 8'h61, 8'd1,  1'b1, 1'b0, 1'b0},
        '{OP_APPEND, STAR_BYTE, 8'd2, 1'b0, 1'b0, 1'b0},
        '{OP_APPEND, 8'h62, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_BEGIN,  8'h00, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_TEXT,   8'h61, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_TEXT,   8'h62, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_TEXT,   8'h61, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_TEXT,   8'h63, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_TEXT,   8'h62, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_CLEAR,  8'h00, 8'd1,  1'b1, 1'b0, 1'b0},
        '{OP_APPEND, 8'hFF, 8'd32, 1'b1, 1'b0, 1'b0},
        '{OP_APPEND, 8'h00, 8'd1,  1'b1, 1'b0, 1'b1},
        '{OP_BEGIN,  8'h00, 8'd1,  1'b1, 1'b0, 1'b1},
        '{OP_TEXT,   8'hFF, 8'd32, 1'b0, 1'b0, 1'b0},
        '{OP_TEXT,   8'hFF, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_APPEND, STAR_BYTE, 8'd1, 1'b1, 1'b0, 1'b1},
        '{OP_CLEAR,  8'hAA, 8'd1,  1'b1, 1'b0, 1'b0},
        '{OP_APPEND, 8'h00, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_BEGIN,  8'h00, 8'd1,  1'b0, 1'b0, 1'b0},
        '{OP_TEXT,   8'h00, 8'd1,  1'b0, 1'b0, 1'b0}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [1:0] s_axis_tuser;   // [1:0] opcode
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [0] matched, [1] pattern_overflow, [7:2] zero

    logic [7:0]     pat_store [PAT_CAP];
    int unsigned    pat_len;
    logic [PAT_CAP:0] live;
    logic           ovf_flag;

    match_result_t  pending_results [$];
    int             mismatches = 0;
    int             words_sent = 0;
    int             burst_left = 0;
    int             cycle_count = 0;
    int             ready_mode = 0;
    int             ready_left = 0;
    int             ready_phase = 0;

    star_wildcard_matcher #(
        .PATTERN_CAPACITY(PAT_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [PAT_CAP:0] close_stars(input logic [PAT_CAP:0] set);
        for (int i = 0; i < pat_len; i++)
        begin
            if (set[i] && pat_store[i] == STAR_BYTE)
                set[i+1] = 1'b1;
        end
        return set;
    endfunction

    function automatic logic [PAT_CAP:0] advance_live(input logic [PAT_CAP:0] set,
                                                     input logic [7:0] b);
        logic [PAT_CAP:0] nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (set[i])
            begin
                if (pat_store[i] == STAR_BYTE)
                    nxt[i] = 1'b1;
                if (pat_store[i] == STAR_BYTE || pat_store[i] == b)
                    nxt[i+1] = 1'b1;
            end
        end
        return close_stars(nxt);
    endfunction

    task automatic match_step(input opcode_t op, input logic [7:0] b,
                              output logic m, output logic o);
        m = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                pat_len = 0;
                ovf_flag = 1'b0;
                live = LIVE_ONE;
            end
            OP_APPEND:
            begin
                if (pat_len < PAT_CAP)
                begin
                    pat_store[pat_len] = b;
                    pat_len++;
                end
                else
                    ovf_flag = 1'b1;
                live = LIVE_ONE;
            end
            OP_BEGIN:
            begin
                live = close_stars(LIVE_ONE);
                m = live[pat_len];
            end
            default:
            begin
                live = advance_live(close_stars(live), b);
                m = live[pat_len];
            end
        endcase
        o = ovf_flag;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 3)
            return STAR_BYTE;
        else if (r <= 6)
            return 8'h61;
        else if (r <= 8)
            return 8'h62;
        else
            return 8'($urandom);
    endfunction

    task automatic send_word(input opcode_t op, input logic [7:0] b, input logic typed,
                             input logic tm, input logic to);
        int gap;
        logic pm;
        logic po;
        match_result_t r;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        words_sent++;
        match_step(op, b, pm, po);
        r.matched  = typed ? tm : pm;
        r.overflow = typed ? to : po;
        pending_results.push_back(r);
    endtask

    task automatic send_text_for_pattern(input bit mangle);
        logic [7:0] txt [$];
        int pos;
        for (int i = 0; i < pat_len; i++)
        begin
            if (pat_store[i] == STAR_BYTE)
                repeat ($urandom_range(0, 3)) txt.push_back(pick_byte());
            else
                txt.push_back(pat_store[i]);
        end
        if (mangle)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    if (txt.size() > 0)
                    begin
                        pos = $urandom_range(0, txt.size() - 1);
                        txt[pos] = 8'($urandom);
                    end
                end
                1: txt.push_back(pick_byte());
                default:
                begin
                    if (txt.size() > 0)
                        void'(txt.pop_back());
                end
            endcase
        end
        send_word(OP_BEGIN, 8'($urandom), 1'b0, 1'b0, 1'b0);
        foreach (txt[k])
            send_word(OP_TEXT, txt[k], 1'b0, 1'b0, 1'b0);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < 100)
            $display("Mismatch on %s at cycle %0d: got %0h, expected %0h",
                     what, cycle_count, got, want);
        mismatches++;
    endtask

    task automatic check_word(input logic [7:0] w);
        match_result_t e;
        if (pending_results.size() == 0)
            report_mismatch("word with no result pending", w, 8'h00);
        else
        begin
            e = pending_results.pop_front();
            if (w[0] !== e.matched)
                report_mismatch("matched", {7'd0, w[0]}, {7'd0, e.matched});
            if (w[1] !== e.overflow)
                report_mismatch("pattern_overflow", {7'd0, w[1]}, {7'd0, e.overflow});
            if (w[7:2] !== 6'd0)
                report_mismatch("padding", {2'd0, w[7:2]}, 8'h00);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("star_wildcard_matcher test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_word(m_axis_tdata);
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 160);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((ready_phase % 5) != 0);
        endcase
    end

    initial
    begin
        int scenario;
        int plen;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= OP_CLEAR;
        s_axis_tdata  <= 8'h00;
        m_axis_tready <= 1'b0;
        pat_len  = 0;
        ovf_flag = 1'b0;
        live     = LIVE_ONE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
        begin
            repeat (DIRECTED[r].reps)
                send_word(DIRECTED[r].op, DIRECTED[r].data, DIRECTED[r].typed,
                          DIRECTED[r].want_matched, DIRECTED[r].want_overflow);
        end

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            scenario = $urandom_range(0, 9);
            if (scenario <= 6)
            begin
                send_word(OP_CLEAR, 8'($urandom), 1'b0, 1'b0, 1'b0);
                plen = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 35)
                                                     : $urandom_range(0, 6);
                repeat (plen) send_word(OP_APPEND, pick_byte(), 1'b0, 1'b0, 1'b0);
                repeat ($urandom_range(1, 3))
                    send_text_for_pattern($urandom_range(0, 2) == 0);
            end
            else if (scenario == 7)
            begin
                repeat ($urandom_range(1, 8))
                    send_word(opcode_t'($urandom_range(0, 3)), 8'($urandom),
                              1'b0, 1'b0, 1'b0);
            end
            else if (scenario == 8)
            begin
                send_word(OP_BEGIN, 8'($urandom), 1'b0, 1'b0, 1'b0);
                repeat ($urandom_range(0, 6))
                    send_word(OP_TEXT, pick_byte(), 1'b0, 1'b0, 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_word(OP_APPEND, pick_byte(), 1'b0, 1'b0, 1'b0);
                send_text_for_pattern(1'b0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("star_wildcard_matcher test passed");
        else
            $display("star_wildcard_matcher test failed");
        $finish;
    end

endmodule
